// ===== rtl/tel_pkg.sv =====
// Shared types, constants and the microcode table of the tab expansion block.
`timescale 1ns / 1ps

package tel_pkg;

  // Field widths fixed by the interface.
  localparam int CharW  = 8;
  localparam int ColW   = 13;
  localparam int StartW = 12;
  localparam int TabW   = 6;
  localparam int CfgW   = 13;
  localparam int CfgIdxW = 2;

  // Default for the widest tab interval honored.
  localparam int MAX_TAB_DEF = 32;

  // Remainder unit: one dividend bit per step over the whole column.
  localparam int DIV_STEPS = ColW;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Character codes.
  localparam logic [CharW-1:0] CH_CR  = 8'h0D;
  localparam logic [CharW-1:0] CH_LF  = 8'h0A;
  localparam logic [CharW-1:0] CH_TAB = 8'h09;
  localparam logic [CharW-1:0] CH_SP  = 8'h20;

  // Column saturation point.
  localparam logic [ColW-1:0] COL_MAX = 13'h1FFF;

  // Register reset values.
  localparam logic [TabW-1:0]   TAB_RESET   = 6'd8;
  localparam logic [StartW-1:0] START_RESET = 12'd0;
  localparam logic [ColW-1:0]   LIMIT_RESET = 13'd80;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_TAB_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_COLUMN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OUTPUT_LIMIT = 2'd2;

  // Microprogram addresses.
  typedef enum logic [2:0] {
    UA_FETCH,
    UA_TAB_INIT,
    UA_DIV_STEP,
    UA_TAB_PREP,
    UA_TAB_SPACE,
    UA_TAB_DONE,
    UA_CHAR,
    UA_LINE_END
  } upc_t;

  // Datapath operations.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_TAB_PREP,
    OP_TAB_SPACE,
    OP_CHAR,
    OP_LINE_END
  } op_t;

  // Sequencing modes.
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_DISPATCH
  } seq_t;

  // Jump conditions.
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_DIV_MORE,
    COND_TAB_MORE
  } cond_t;

  // One control word.
  typedef struct packed {
    op_t   op;
    seq_t  seq;
    cond_t cond;
    upc_t  target;
  } ctrl_t;

  // Status the datapath returns to the sequencer.
  typedef struct packed {
    upc_t disp;
    logic stall;
    logic div_more;
    logic tab_more;
  } dp_status_t;

  // Control store.
  function automatic ctrl_t ucode(input upc_t addr);
    ctrl_t w;
    w = '{op: OP_NOP, seq: SEQ_JUMP, cond: COND_ALWAYS, target: UA_FETCH};
    unique case (addr)
      UA_FETCH:     w = '{op: OP_NOP,       seq: SEQ_DISPATCH, cond: COND_ALWAYS,
                          target: UA_FETCH};
      UA_TAB_INIT:  w = '{op: OP_DIV_INIT,  seq: SEQ_NEXT,     cond: COND_ALWAYS,
                          target: UA_FETCH};
      UA_DIV_STEP:  w = '{op: OP_DIV_STEP,  seq: SEQ_JUMP,     cond: COND_DIV_MORE,
                          target: UA_DIV_STEP};
      UA_TAB_PREP:  w = '{op: OP_TAB_PREP,  seq: SEQ_NEXT,     cond: COND_ALWAYS,
                          target: UA_FETCH};
      UA_TAB_SPACE: w = '{op: OP_TAB_SPACE, seq: SEQ_JUMP,     cond: COND_TAB_MORE,
                          target: UA_TAB_SPACE};
      UA_TAB_DONE:  w = '{op: OP_NOP,       seq: SEQ_JUMP,     cond: COND_ALWAYS,
                          target: UA_FETCH};
      UA_CHAR:      w = '{op: OP_CHAR,      seq: SEQ_JUMP,     cond: COND_ALWAYS,
                          target: UA_FETCH};
      UA_LINE_END:  w = '{op: OP_LINE_END,  seq: SEQ_JUMP,     cond: COND_ALWAYS,
                          target: UA_FETCH};
      default:      w = '{op: OP_NOP,       seq: SEQ_JUMP,     cond: COND_ALWAYS,
                          target: UA_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/tel_useq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
`timescale 1ns / 1ps

module tel_useq import tel_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t status,
  output ctrl_t      ctrl,
  output logic       in_ready,
  output logic       in_accept
);

  upc_t upc;
  upc_t upc_next;
  upc_t upc_inc;
  logic cond_true;

  // Current control word.
  assign ctrl      = ucode(upc);
  assign in_ready  = (ctrl.seq == SEQ_DISPATCH);
  assign in_accept = in_ready && in_valid;
  assign upc_inc   = upc_t'(3'(upc + 3'd1));

  // Jump condition select.
  always_comb begin
    unique case (ctrl.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_DIV_MORE: cond_true = status.div_more;
      COND_TAB_MORE: cond_true = status.tab_more;
      default:       cond_true = 1'b0;
    endcase
  end

  // Next step; a stalled step repeats until the output word slot frees up.
  always_comb begin
    if (status.stall) begin
      upc_next = upc;
    end else begin
      unique case (ctrl.seq)
        SEQ_NEXT:     upc_next = upc_inc;
        SEQ_JUMP:     upc_next = cond_true ? ctrl.target : upc_inc;
        SEQ_DISPATCH: upc_next = in_valid ? status.disp : UA_FETCH;
        default:      upc_next = UA_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UA_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== rtl/tel_dpath.sv =====
// Datapath: line state, configuration registers, remainder unit and output word register.
`timescale 1ns / 1ps

module tel_dpath import tel_pkg::*; #(
  parameter int MAX_TAB = MAX_TAB_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_t              ctrl,
  input  logic               in_accept,
  input  logic [CharW-1:0]   in_char,
  input  logic               end_of_file,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [CharW-1:0]   out_char,
  output logic               char_valid,
  output logic               line_done,
  output logic [ColW-1:0]    written_count,
  output logic               no_line,
  output logic               last,
  output dp_status_t         status
);

  localparam int TW = $clog2(MAX_TAB + 1);
  localparam logic [TabW:0] MaxTabCmp = 7'(MAX_TAB);

  // Configuration registers.
  logic [TabW-1:0]   tab_interval;
  logic [StartW-1:0] start_column;
  logic [ColW-1:0]   output_limit;

  // Line state.
  logic [ColW-1:0] column;
  logic [ColW-1:0] remaining;
  logic [ColW-1:0] written;
  logic            discarding;

  // Working registers.
  logic [CharW-1:0]     ch;
  logic                 eof_q;
  logic [TW-1:0]        acc;
  logic [ColW-1:0]      dvd;
  logic [DIV_CNT_W-1:0] divcnt;
  logic [ColW:0]        p;
  logic [TW-1:0]        count;

  logic [TW-1:0]    t_eff;
  logic [TW:0]      sh;
  logic [TW-1:0]    acc_next;
  logic [TW-1:0]    count_init;
  logic [ColW:0]    stop;
  logic [ColW-1:0]  col_after_tab;
  logic [ColW-1:0]  col_inc;
  logic             slot_free;
  logic             emit_want;
  logic             stall;
  logic             do_emit;
  logic             rem_last;
  logic             none;
  upc_t             disp;

  logic [CharW-1:0] res_char;
  logic             res_cv;
  logic             res_done;
  logic [ColW-1:0]  res_count;
  logic             res_none;
  logic             res_last;

  // Tab interval, clamped to the widest one honored.
  assign t_eff = ({1'b0, tab_interval} > MaxTabCmp) ? TW'(MAX_TAB) : TW'(tab_interval);

  // Restoring remainder step: bring in one dividend bit, subtract when it fits.
  assign sh       = {acc, dvd[ColW-1]};
  assign acc_next = (sh >= {1'b0, t_eff}) ? TW'(sh - {1'b0, t_eff}) : TW'(sh);

  // Columns up to the next tab stop, and the saturated column after it.
  assign count_init    = t_eff - acc;
  assign stop          = {1'b0, column} + (ColW + 1)'(count_init);
  assign col_after_tab = (stop > {1'b0, COL_MAX}) ? COL_MAX : stop[ColW-1:0];
  assign col_inc       = (column < COL_MAX) ? column + 13'd1 : column;

  assign rem_last = (remaining == 13'd1);
  assign none     = eof_q && (column == '0);

  // Which steps want the output word slot.
  always_comb begin
    unique case (ctrl.op)
      OP_TAB_SPACE: emit_want = (p >= {2'b00, start_column});
      OP_CHAR:      emit_want = (column >= {1'b0, start_column});
      OP_LINE_END:  emit_want = 1'b1;
      default:      emit_want = 1'b0;
    endcase
  end

  assign slot_free = !out_valid || out_ready;
  assign stall     = emit_want && !slot_free;
  assign do_emit   = emit_want && slot_free;

  // Dispatch on the offered byte.
  always_comb begin
    priority if (end_of_file || in_char == CH_LF) begin
      disp = UA_LINE_END;
    end else if (in_char == CH_CR || discarding) begin
      disp = UA_FETCH;
    end else if (in_char == CH_TAB) begin
      disp = (t_eff == '0) ? UA_FETCH : UA_TAB_INIT;
    end else begin
      disp = UA_CHAR;
    end
  end

  assign status.disp     = disp;
  assign status.stall    = stall;
  assign status.div_more = (divcnt != DIV_CNT_W'(1));
  assign status.tab_more = (count != TW'(1)) && !(emit_want && rem_last);

  // Result word contents per operation.
  always_comb begin
    res_char  = '0;
    res_cv    = 1'b0;
    res_done  = 1'b0;
    res_count = '0;
    res_none  = 1'b0;
    res_last  = 1'b1;
    unique case (ctrl.op)
      OP_TAB_SPACE: begin
        res_char = CH_SP;
        res_cv   = 1'b1;
        res_last = rem_last || (count == TW'(1));
      end
      OP_CHAR: begin
        res_char = ch;
        res_cv   = 1'b1;
      end
      OP_LINE_END: begin
        res_none  = none;
        res_done  = !none;
        res_count = none ? '0 : written;
      end
      default: begin
        res_last = 1'b1;
      end
    endcase
  end

  // Output word register: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output word register: payload.
  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_char      <= res_char;
      char_valid    <= res_cv;
      line_done     <= res_done;
      written_count <= res_count;
      no_line       <= res_none;
      last          <= res_last;
    end
  end

  // Line state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tab_interval <= TAB_RESET;
      start_column <= START_RESET;
      output_limit <= LIMIT_RESET;
      column       <= '0;
      written      <= '0;
      remaining    <= LIMIT_RESET;
      discarding   <= 1'b0;
    end else begin
      unique case (ctrl.op)
        OP_TAB_PREP: begin
          column <= col_after_tab;
        end
        OP_TAB_SPACE: begin
          if (do_emit) begin
            written    <= written + 13'd1;
            remaining  <= remaining - 13'd1;
            discarding <= rem_last;
          end
        end
        OP_CHAR: begin
          if (!stall) begin
            column <= col_inc;
          end
          if (do_emit) begin
            written    <= written + 13'd1;
            remaining  <= remaining - 13'd1;
            discarding <= rem_last;
          end
        end
        OP_LINE_END: begin
          if (!stall) begin
            column     <= '0;
            written    <= '0;
            remaining  <= output_limit;
            discarding <= (output_limit == '0);
          end
        end
        default: begin
        end
      endcase

      // Register writes; a new limit takes effect at once only at column zero.
      if (cfg_write) begin
        case (cfg_index)
          CFG_TAB_INTERVAL: tab_interval <= cfg_data[TabW-1:0];
          CFG_START_COLUMN: start_column <= cfg_data[StartW-1:0];
          CFG_OUTPUT_LIMIT: begin
            output_limit <= cfg_data;
            if (column == '0) begin
              written    <= '0;
              remaining  <= cfg_data;
              discarding <= (cfg_data == '0);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Working registers: input latch, remainder unit, tab loop.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ch    <= in_char;
      eof_q <= end_of_file;
    end
    unique case (ctrl.op)
      OP_DIV_INIT: begin
        acc    <= '0;
        dvd    <= column;
        divcnt <= DIV_CNT_W'(DIV_STEPS);
      end
      OP_DIV_STEP: begin
        acc    <= acc_next;
        dvd    <= {dvd[ColW-2:0], 1'b0};
        divcnt <= divcnt - DIV_CNT_W'(1);
      end
      OP_TAB_PREP: begin
        p     <= {1'b0, column};
        count <= count_init;
      end
      OP_TAB_SPACE: begin
        if (!stall) begin
          p     <= p + 14'd1;
          count <= count - TW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/tab_expand_line_window.sv =====
// Top level of the tab expansion block with a column window.
`timescale 1ns / 1ps

// Takes one byte per input word, drops carriage returns, expands tabs to the
// next tab stop and passes on only the columns from start_column on, at most
// output_limit characters per line; a line feed or end of file closes the line
// with a count word, or a no-line word for end of file at column zero. A program
// counter steps each word through a microprogram: a byte takes a dispatch and
// an emit step, a carriage return or discarded byte only the dispatch, a line
// feed or end of file a dispatch and a close step, and a tab a dispatch, setup,
// bit-serial remainder loop (column modulo interval), prep, space steps up to
// the stop (at most the interval) and done. Emit steps wait while the output
// word register is full and not taken. Configuration registers are for the
// user to write only while no input word is in flight; the block does not check.
module tab_expand_line_window import tel_pkg::*; #(
  parameter int MAX_TAB = MAX_TAB_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CharW-1:0]   in_char,
  input  logic               end_of_file,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CharW-1:0]   out_char,
  output logic               char_valid,
  output logic               line_done,
  output logic [ColW-1:0]    written_count,
  output logic               no_line,
  output logic               last,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  ctrl_t      ctrl;
  dp_status_t status;
  logic       in_accept;

  // Program counter and control store.
  tel_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .status    (status),
    .ctrl      (ctrl),
    .in_ready  (in_ready),
    .in_accept (in_accept)
  );

  // Datapath driven by the control word.
  tel_dpath #(
    .MAX_TAB (MAX_TAB)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .in_accept     (in_accept),
    .in_char       (in_char),
    .end_of_file   (end_of_file),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_char      (out_char),
    .char_valid    (char_valid),
    .line_done     (line_done),
    .written_count (written_count),
    .no_line       (no_line),
    .last          (last),
    .status        (status)
  );

endmodule

// ===== rtl/tel_checker.sv =====
// Port-level checks on the tab expansion block, bound to its top level.
`timescale 1ns / 1ps

module tel_checker import tel_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CharW-1:0]   out_char,
  input logic               char_valid,
  input logic               line_done,
  input logic [ColW-1:0]    written_count,
  input logic               no_line,
  input logic               last
);

  // Reset empties the output word register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present right after reset");

  // A word that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last)
      && $stable(written_count))
    else $error("output word changed while stalled");

  // Every word is exactly one kind: a character, a line close or a no-line report.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({char_valid, line_done, no_line}))
    else $error("output word kind is not unique");

  // Line close and no-line reports always end the words of their input.
  a_close_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (line_done || no_line) |-> last)
    else $error("line report without last mark");

  // A count only travels with a line close.
  a_count_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_done |-> written_count == '0)
    else $error("count present on a word that does not close a line");

endmodule

bind tab_expand_line_window tel_checker u_tel_checker (.*);

// ===== sim/tab_expand_line_window_checker.sv =====
// Checker that predicts and compares the output words of the tab expansion block.
`timescale 1ns / 1ps

module tab_expand_line_window_checker import tel_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [CharW-1:0]   in_char,
  input  logic               end_of_file,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [CharW-1:0]   out_char,
  input  logic               char_valid,
  input  logic               line_done,
  input  logic [ColW-1:0]    written_count,
  input  logic               no_line,
  input  logic               last,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output int                 mismatches,
  output int                 words_owed
);

  localparam int ReportMax = 10;

  // One output word as the block presents it.
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             valid;
    logic             done;
    logic [ColW-1:0]  count;
    logic             none;
    logic             last;
  } out_word_t;

  out_word_t expected_words[$];
  out_word_t got_word;
  out_word_t want_word;
  int        fail_count = 0;

  // Mirror of the registers and of the line state.
  logic [TabW-1:0]   tab_step;
  logic [StartW-1:0] first_col;
  logic [ColW-1:0]   line_limit;
  logic [ColW-1:0]   line_col;
  logic [ColW-1:0]   chars_left;
  logic [ColW-1:0]   chars_written;
  logic              dropping;

  initial begin
    mismatches = 0;
    words_owed = 0;
  end

  // Restart the line: column zero, fresh budget from the limit register.
  function automatic void open_line();
    line_col      = '0;
    chars_written = '0;
    chars_left    = line_limit;
    dropping      = (line_limit == '0);
  endfunction

  // Queue one emitted character; returns 1 once the line budget is spent.
  function automatic bit emit_char(input logic [CharW-1:0] ch);
    expected_words.push_back(out_word_t'{ch: ch, valid: 1'b1, done: 1'b0, count: '0,
                                         none: 1'b0, last: 1'b0});
    chars_written = chars_written + ColW'(1);
    chars_left    = chars_left - ColW'(1);
    if (chars_left == '0) begin
      dropping = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the words that one accepted input word produces.
  function automatic void predict_expansion(input logic [CharW-1:0] ch, input logic eof);
    int unsigned step;
    int unsigned stop;
    int unsigned pos;
    int          queued;
    out_word_t   w;
    queued = expected_words.size();

    // Line feed or end of file always closes with exactly one word.
    if (eof || ch == CH_LF) begin
      if (eof && line_col == '0)
        w = out_word_t'{ch: '0, valid: 1'b0, done: 1'b0, count: '0, none: 1'b1, last: 1'b1};
      else
        w = out_word_t'{ch: '0, valid: 1'b0, done: 1'b1, count: chars_written, none: 1'b0,
                        last: 1'b1};
      expected_words.push_back(w);
      open_line();
      return;
    end
    if (ch == CH_CR || dropping)
      return;

    if (ch == CH_TAB) begin
      step = (tab_step > MAX_TAB_DEF) ? MAX_TAB_DEF : tab_step;
      if (step == 0)
        return;
      // Spaces up to the next stop; only columns inside the window are sent.
      stop = (line_col + step) - ((line_col + step) % step);
      for (pos = line_col; pos < stop; pos++) begin
        if (pos >= first_col) begin
          if (emit_char(CH_SP))
            break;
        end
      end
      line_col = (stop > COL_MAX) ? COL_MAX : stop[ColW-1:0];
    end else begin
      if (line_col >= first_col)
        void'(emit_char(ch));
      if (line_col < COL_MAX)
        line_col = line_col + ColW'(1);
    end

    // Mark the final word of this input.
    if (expected_words.size() > queued) begin
      w = expected_words.pop_back();
      w.last = 1'b1;
      expected_words.push_back(w);
    end
  endfunction

  function automatic void log_failure(input string what, input out_word_t exp_w,
                                      input out_word_t act_w);
    fail_count++;
    if (fail_count <= ReportMax)
      $display("%0t %s: expected char %02h valid %0b done %0b count %0d none %0b last %0b,",
               $realtime, what, exp_w.ch, exp_w.valid, exp_w.done, exp_w.count, exp_w.none,
               exp_w.last,
               " got char %02h valid %0b done %0b count %0d none %0b last %0b",
               act_w.ch, act_w.valid, act_w.done, act_w.count, act_w.none, act_w.last);
  endfunction

  // Watch both channels and the register port at every rising edge.
  always @(posedge clk) begin
    if (rst) begin
      expected_words.delete();
      tab_step   = TAB_RESET;
      first_col  = START_RESET;
      line_limit = LIMIT_RESET;
      open_line();
    end else begin
      // Compare a taken output word against the oldest expectation.
      if (out_valid && out_ready) begin
        got_word = out_word_t'{out_char, char_valid, line_done, written_count, no_line, last};
        if (expected_words.size() == 0) begin
          log_failure("unexpected word", '0, got_word);
        end else begin
          want_word = expected_words.pop_front();
          if (got_word !== want_word)
            log_failure("word mismatch", want_word, got_word);
        end
      end

      // A new limit takes effect at once only before the first column.
      if (cfg_write) begin
        case (cfg_index)
          CFG_TAB_INTERVAL: tab_step = cfg_data[TabW-1:0];
          CFG_START_COLUMN: first_col = cfg_data[StartW-1:0];
          CFG_OUTPUT_LIMIT: begin
            line_limit = cfg_data;
            if (line_col == '0)
              open_line();
          end
          default: ;
        endcase
      end

      if (in_valid && in_ready)
        predict_expansion(in_char, end_of_file);
    end
    mismatches <= fail_count;
    words_owed <= expected_words.size();
  end

endmodule

// ===== sim/tab_expand_line_window_tb.sv =====
// Testbench top for the tab expansion block: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tab_expand_line_window_tb;
  import tel_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 60;
  localparam int HoldCycles  = 300;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [CharW-1:0]   in_char;
  logic               end_of_file;
  logic               out_valid;
  logic               out_ready;
  logic [CharW-1:0]   out_char;
  logic               char_valid;
  logic               line_done;
  logic [ColW-1:0]    written_count;
  logic               no_line;
  logic               last;
  logic               cfg_write;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;

  int mismatches;
  int words_owed;
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_requests = 0;
  int quiet_cycles  = 0;
  int words_sent    = 0;

  tab_expand_line_window u_dut (.*);

  tab_expand_line_window_checker u_checker (.*);

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int seen;
    seen = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != seen) begin
        seen = hold_requests;
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
    end
  end

  // Stop the run when nothing has moved on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tab_expand_line_window_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word, after a random gap, and hold it until it is taken.
  task automatic send_word(input logic [CharW-1:0] ch, input logic eof);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_char     <= ch;
    end_of_file <= eof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Stop sending and wait until every expected word is out and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges.
  task automatic program_regs(input int tab, input int start, input int limit);
    cfg_write <= 1'b1;
    cfg_index <= CFG_TAB_INTERVAL;
    cfg_data  <= CfgW'(tab);
    @(posedge clk);
    cfg_index <= CFG_START_COLUMN;
    cfg_data  <= CfgW'(start);
    @(posedge clk);
    cfg_index <= CFG_OUTPUT_LIMIT;
    cfg_data  <= CfgW'(limit);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Mostly printable text and tabs, some carriage returns, some raw bytes.
  function automatic logic [CharW-1:0] pick_char();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55)
      return CharW'($urandom_range(126, 32));
    if (r < 75)
      return CH_TAB;
    if (r < 82)
      return CH_CR;
    return CharW'($urandom_range(255, 0));
  endfunction

  // One line of random content, closed by a line feed or by end of file.
  task automatic send_line(input int max_len);
    int len;
    len = $urandom_range(max_len, 0);
    repeat (len) send_word(pick_char(), 1'b0);
    if ($urandom_range(99, 0) < 85)
      send_word(CH_LF, 1'b0);
    else
      send_word(CharW'($urandom_range(255, 0)), 1'b1);
  endtask

  // Pick a register setting, with the edges of each range well represented.
  task automatic random_regs();
    int tab;
    int start;
    int limit;
    case ($urandom_range(7, 0))
      0:       tab = 0;
      1:       tab = 1;
      2:       tab = MAX_TAB_DEF;
      3:       tab = MAX_TAB_DEF + 1;
      4:       tab = 63;
      default: tab = $urandom_range(9, 2);
    endcase
    start = ($urandom_range(7, 0) == 0) ? $urandom_range(4095, 0) : $urandom_range(5, 0);
    limit = ($urandom_range(5, 0) == 0) ? 4096 : $urandom_range(12, 1);
    program_regs(tab, start, limit);
  endtask

  task automatic random_phase(input int tx_pct, input int rx_pct, input int words);
    int goal;
    goal = words_sent + words;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    while (words_sent < goal) begin
      settle();
      random_regs();
      repeat (3) send_line(10);
    end
  endtask

  // One long line of wide tabs: the window opens in the middle of a tab and
  // the limit is reached inside a later tab, so the rest of the line is dropped.
  task automatic long_line();
    settle();
    program_regs(MAX_TAB_DEF, 1000, 40);
    repeat (36) begin
      if ($urandom_range(3, 0) == 0)
        send_word(CharW'($urandom_range(126, 32)), 1'b0);
      send_word(CH_TAB, 1'b0);
    end
    send_word(CharW'($urandom_range(126, 32)), 1'b0);
    send_word(CH_LF, 1'b0);
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_char     = '0;
    end_of_file = 1'b0;
    cfg_write   = 1'b0;
    cfg_index   = CFG_TAB_INTERVAL;
    cfg_data    = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: end of file with no line, byte extremes, dropped carriage
    // return, a tab from mid-stop, end of file closing a started line.
    program_regs(8, 0, 80);
    send_word(CH_LF, 1'b1);
    send_word(8'h41, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_CR, 1'b0);
    send_word(CH_TAB, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(8'h78, 1'b0);
    send_word(8'hFF, 1'b1);

    // Tabs that vanish, bytes before the window, limit reached, rest dropped.
    settle();
    program_regs(0, 2, 3);
    send_word(8'h61, 1'b0);
    send_word(CH_TAB, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h63, 1'b0);
    send_word(8'h64, 1'b0);
    send_word(8'h65, 1'b0);
    send_word(CH_TAB, 1'b0);
    send_word(CH_LF, 1'b0);

    // Interval above the widest stop, limit reached inside the tab.
    settle();
    program_regs(63, 0, 5);
    send_word(CH_TAB, 1'b0);
    send_word(CH_LF, 1'b0);

    // Tab lying entirely before the window.
    settle();
    program_regs(4, 10, 1);
    send_word(CH_TAB, 1'b0);
    send_word(CH_LF, 1'b0);

    // Zero limit: no characters emitted, columns frozen.
    settle();
    program_regs(8, 0, 0);
    send_word(8'h61, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(8'h61, 1'b1);

    // A limit written mid-line only applies from the next line on.
    settle();
    program_regs(8, 0, 4);
    send_word(8'h61, 1'b0);
    settle();
    program_regs(8, 0, 1);
    send_word(8'h62, 1'b0);
    send_word(8'h63, 1'b0);
    send_word(CH_LF, 1'b0);
    send_word(8'h64, 1'b0);
    send_word(8'h65, 1'b0);
    send_word(CH_LF, 1'b0);

    // Random lines under three idling patterns.
    random_phase(30, 46, 15);
    random_phase(46, 30, 15);
    random_phase(0, 0, 15);

    // Receiver holds off while tab-heavy words keep coming.
    settle();
    program_regs(8, 0, 4096);
    hold_requests <= hold_requests + 1;
    repeat (20) send_word(($urandom_range(1, 0) == 1) ? CH_TAB : pick_char(), 1'b0);
    send_word(CH_LF, 1'b0);

    long_line();

    settle();
    if (mismatches == 0)
      $display("tab_expand_line_window_tb passed");
    else
      $display("tab_expand_line_window_tb failed");
    $finish;
  end

endmodule
